/* hdl/cdc_pkg.sv */
// ----------------------------------------------------------------------------
// cdc_pkg
// Types and fixed constants of the coherence directory controller.
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam int CORES            = 16;
  localparam int SLICES           = 16;
  localparam int SETS_PER_SLICE   = 64;
  localparam int LINE_OFFSET_BITS = 6;
  localparam int ADDRESS_BITS     = 40;
  localparam int SLICE_W          = $clog2(SLICES);
  localparam int SET_W            = $clog2(SETS_PER_SLICE);
  localparam int SET_IDX_W        = SLICE_W + SET_W;
  localparam int LINE_W           = ADDRESS_BITS - LINE_OFFSET_BITS;
  localparam int TAG_W            = LINE_W - SET_IDX_W;
  localparam int SETS_TOTAL       = SLICES * SETS_PER_SLICE;
  localparam int CORE_W           = 4;
  localparam int HOLD_W           = 8;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_SHARED = 2'd0;
  localparam func_t FUNC_EXCL   = 2'd1;
  localparam func_t FUNC_QUERY  = 2'd2;
  localparam func_t FUNC_DELETE = 2'd3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_INVAL = 2'd0;
  localparam kind_t KIND_DOWN  = 2'd1;
  localparam kind_t KIND_REPLY = 2'd2;

  typedef struct packed {
    func_t                   func;
    logic [CORE_W-1:0]       core;
    logic [ADDRESS_BITS-1:0] address;
  } req_t;

  typedef struct packed {
    kind_t                   kind;
    logic [CORE_W-1:0]       target_core;
    logic [ADDRESS_BITS-1:0] line_address;
    logic                    granted_shared;
    logic                    sole_owner;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [CORE_W-1:0] owner;
    logic [HOLD_W-1:0] holders;
    logic [CORES-1:0]  sharers;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DECIDE,
    ST_SEND
  } state_t;

endpackage

/* hdl/coherence_directory_controller.sv */
// ----------------------------------------------------------------------------
// coherence_directory_controller
// Set-associative MSI coherence directory with a way-by-way lookup sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                  | beat
//  req     | req_valid, req_ready     | one request: func, core, address
//  rsp     | rsp_valid, rsp_ready     | one command or the final reply
//
//  A request steps through a READ and an EVAL state per way (one entry read
//  per way through the single read port of the store), then a DECIDE state,
//  then SEND, which issues each invalidate/downgrade beat and then the reply.
//  After reset a clearing pass zeroes all 1024*WAYS store entries; no
//  request is taken meanwhile. A stalled rsp holds the sequencer in place.
module coherence_directory_controller #(
  parameter int WAYS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cdc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cdc_pkg::rsp_t rsp
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int DEPTH = cdc_pkg::SETS_TOTAL * WAYS;
  localparam int AW    = $clog2(DEPTH);

  cdc_pkg::state_t state, state_next;

  cdc_pkg::func_t                      func;
  logic [cdc_pkg::CORE_W-1:0]          core;
  logic [cdc_pkg::TAG_W-1:0]           tag;
  logic [cdc_pkg::SET_IDX_W-1:0]       set_idx;
  logic [cdc_pkg::ADDRESS_BITS-1:0]    laddr;
  logic [WAY_W:0]                      cnt;
  logic [AW-1:0]                       clr_cnt;
  logic                                hit, inv_found;
  logic [WAY_W-1:0]                    hit_w, inv_w, min_w;
  cdc_pkg::entry_t                     hit_ent, min_ent, rd_data;
  logic [cdc_pkg::CORES-1:0]           cmd_mask;
  cdc_pkg::kind_t                      cmd_kind;
  logic [cdc_pkg::ADDRESS_BITS-1:0]    cmd_addr;
  logic                                rep_gs, rep_so;

  logic                                wr_en, dec_wr;
  logic [AW-1:0]                       wr_addr, rd_addr;
  cdc_pkg::entry_t                     wr_data, dec_data;
  logic [cdc_pkg::CORES-1:0]           dec_mask, cbit;
  cdc_pkg::kind_t                      dec_kind;
  logic [cdc_pkg::ADDRESS_BITS-1:0]    dec_addr, vaddr;
  logic                                dec_gs, dec_so, alone, slot_free;
  logic [WAY_W-1:0]                    wr_way;
  logic [cdc_pkg::CORE_W-1:0]          low_idx;

  function automatic logic [AW-1:0] ent_addr(logic [cdc_pkg::SET_IDX_W-1:0] s,
                                             logic [WAY_W-1:0] w);
    ent_addr = AW'(s) * AW'(WAYS) + AW'(w);
  endfunction

  cdc_dir_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cbit      = cdc_pkg::CORES'(1) << core;
  assign alone     = (hit_ent.owner == core) && (hit_ent.holders == 8'd1);
  assign vaddr     = {min_ent.tag, set_idx, {cdc_pkg::LINE_OFFSET_BITS{1'b0}}};
  assign slot_free = !rsp_valid || rsp_ready;
  assign wr_way    = hit ? hit_w : (inv_found ? inv_w : min_w);
  assign rd_addr   = ent_addr(set_idx, cnt[WAY_W-1:0]);
  assign wr_en     = (state == cdc_pkg::ST_CLEAR) ||
                     ((state == cdc_pkg::ST_DECIDE) && dec_wr);
  assign wr_addr   = (state == cdc_pkg::ST_CLEAR) ? clr_cnt : ent_addr(set_idx, wr_way);
  assign wr_data   = (state == cdc_pkg::ST_CLEAR) ? '0 : dec_data;
  assign req_ready = (state == cdc_pkg::ST_IDLE);

  always_comb begin
    low_idx = '0;
    for (int i = cdc_pkg::CORES - 1; i >= 0; i--) begin
      if (cmd_mask[i]) begin
        low_idx = cdc_pkg::CORE_W'(i);
      end
    end
  end

  always_comb begin
    cdc_pkg::entry_t nd;
    cdc_pkg::entry_t tk;
    nd       = hit_ent;
    tk.valid   = 1'b1;
    tk.tag     = tag;
    tk.owner   = core;
    tk.holders = 8'd1;
    tk.sharers = cbit;
    dec_wr   = 1'b0;
    dec_data = '0;
    dec_mask = '0;
    dec_kind = cdc_pkg::KIND_INVAL;
    dec_addr = laddr;
    dec_gs   = 1'b0;
    dec_so   = 1'b0;
    if (func != cdc_pkg::FUNC_DELETE && !hit && !inv_found) begin
      dec_mask = min_ent.sharers;
      dec_addr = vaddr;
    end
    unique case (func)
      cdc_pkg::FUNC_DELETE: begin
        if (hit && (hit_ent.sharers & cbit) != '0) begin
          nd.sharers = hit_ent.sharers & ~cbit;
          if (nd.holders != '0) begin
            nd.holders = nd.holders - 8'd1;
          end
          if (nd.holders == '0) begin
            nd.valid = 1'b0;
          end
          dec_wr   = 1'b1;
          dec_data = nd;
        end
      end
      cdc_pkg::FUNC_SHARED: begin
        if (!hit) begin
          dec_wr   = 1'b1;
          dec_data = tk;
        end else if (alone) begin
          dec_gs = 1'b0;
        end else begin
          if (nd.holders != 8'hff) begin
            nd.holders = nd.holders + 8'd1;
          end
          nd.sharers = hit_ent.sharers | cbit;
          if (hit_ent.holders <= 8'd1) begin
            nd.owner = '0;
            dec_mask = hit_ent.sharers;
            dec_kind = cdc_pkg::KIND_DOWN;
          end
          dec_wr   = 1'b1;
          dec_data = nd;
          dec_gs   = 1'b1;
        end
      end
      cdc_pkg::FUNC_EXCL: begin
        if (hit && !alone) begin
          dec_mask = hit_ent.sharers & ~cbit;
        end
        if (!hit || !alone) begin
          dec_wr   = 1'b1;
          dec_data = tk;
        end
      end
      cdc_pkg::FUNC_QUERY: begin
        if (hit) begin
          dec_so = alone;
        end else begin
          dec_wr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cdc_pkg::ST_CLEAR:  if (clr_cnt == AW'(DEPTH - 1)) state_next = cdc_pkg::ST_IDLE;
      cdc_pkg::ST_IDLE:   if (req_valid) state_next = cdc_pkg::ST_READ;
      cdc_pkg::ST_READ:   state_next = cdc_pkg::ST_EVAL;
      cdc_pkg::ST_EVAL:   state_next = (cnt == (WAY_W+1)'(WAYS - 1)) ? cdc_pkg::ST_DECIDE
                                                                     : cdc_pkg::ST_READ;
      cdc_pkg::ST_DECIDE: state_next = cdc_pkg::ST_SEND;
      cdc_pkg::ST_SEND:   if (slot_free && cmd_mask == '0) state_next = cdc_pkg::ST_IDLE;
      default:            state_next = cdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
      cmd_mask  <= '0;
    end else begin
      if (rsp_valid && rsp_ready && state != cdc_pkg::ST_SEND) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        cdc_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
        end
        cdc_pkg::ST_IDLE: begin
          if (req_valid) begin
            func      <= req.func;
            core      <= req.core;
            tag       <= req.address[cdc_pkg::ADDRESS_BITS-1 -: cdc_pkg::TAG_W];
            set_idx   <= req.address[cdc_pkg::LINE_OFFSET_BITS +: cdc_pkg::SET_IDX_W];
            laddr     <= {req.address[cdc_pkg::ADDRESS_BITS-1:cdc_pkg::LINE_OFFSET_BITS],
                          {cdc_pkg::LINE_OFFSET_BITS{1'b0}}};
            cnt       <= '0;
            hit       <= 1'b0;
            inv_found <= 1'b0;
          end
        end
        cdc_pkg::ST_READ: ;
        cdc_pkg::ST_EVAL: begin
          if (rd_data.valid && rd_data.tag == tag && !hit) begin
            hit     <= 1'b1;
            hit_w   <= cnt[WAY_W-1:0];
            hit_ent <= rd_data;
          end
          if (!rd_data.valid && !inv_found) begin
            inv_found <= 1'b1;
            inv_w     <= cnt[WAY_W-1:0];
          end
          if (cnt == '0 || rd_data.holders < min_ent.holders) begin
            min_w   <= cnt[WAY_W-1:0];
            min_ent <= rd_data;
          end
          cnt <= cnt + (WAY_W+1)'(1);
        end
        cdc_pkg::ST_DECIDE: begin
          cmd_mask <= dec_mask;
          cmd_kind <= dec_kind;
          cmd_addr <= dec_addr;
          rep_gs   <= dec_gs;
          rep_so   <= dec_so;
        end
        cdc_pkg::ST_SEND: begin
          if (slot_free) begin
            rsp_valid <= 1'b1;
            if (cmd_mask != '0) begin
              rsp.kind           <= cmd_kind;
              rsp.target_core    <= low_idx;
              rsp.line_address   <= cmd_addr;
              rsp.granted_shared <= 1'b0;
              rsp.sole_owner     <= 1'b0;
              rsp.last           <= 1'b0;
              cmd_mask[low_idx]  <= 1'b0;
            end else begin
              rsp.kind           <= cdc_pkg::KIND_REPLY;
              rsp.target_core    <= core;
              rsp.line_address   <= laddr;
              rsp.granted_shared <= rep_gs;
              rsp.sole_owner     <= rep_so;
              rsp.last           <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_mask_idle: assert property (@(posedge clk) disable iff (rst)
    state == cdc_pkg::ST_IDLE |-> cmd_mask == '0)
    else $error("command mask pending while idle");

  a_last_reply: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.last == (rsp.kind == cdc_pkg::KIND_REPLY))
    else $error("last flag disagrees with beat kind");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == cdc_pkg::ST_READ)
    else $error("lookup did not start after request");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == cdc_pkg::ST_CLEAR || state == cdc_pkg::ST_DECIDE))
    else $error("store written outside clear or decide");

endmodule

/* hdl/cdc_dir_ram.sv */
// ----------------------------------------------------------------------------
// cdc_dir_ram
// Directory entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cdc_dir_ram #(
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  cdc_pkg::entry_t            wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output cdc_pkg::entry_t            rd_data
);

  cdc_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
